/* rtl/arith_enc_pkg.sv */
// Shared types and constants for the arithmetic encoder.
// Depends on nothing; used by the controller, the datapath and the top level.
package arith_enc_pkg;

  localparam int FREQ_W  = 14;
  localparam int COUNT_W = 32;

  typedef struct packed {
    logic              func;
    logic [FREQ_W-1:0] cum_upper;
    logic [FREQ_W-1:0] cum_lower;
    logic [FREQ_W-1:0] total_count;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               run_last;
    logic [COUNT_W-1:0] stream_bytes;
    logic               pending_saturated;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_UPDATE,
    ST_RENORM,
    ST_FOLLOW,
    ST_TAIL,
    ST_FLUSH,
    ST_WAIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input word
    logic mul;         // form both products
    logic div_start;   // start the shared divider
    logic update;      // apply quotients to the interval
    logic renorm;      // perform one renormalization step
    logic follow;      // shift out one follow bit
    logic tail;        // pending bump and tail bit
    logic flush;       // emit final partial byte or the held byte
    logic take;        // output word consumed
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic renorm_stop;  // no renormalization case applies
    logic renorm_mid;   // the step only adds a follow bit
    logic pending_zero;
    logic out_full;     // output register holds a word
    logic is_finish;
  } dp_stat_t;

endpackage

/* rtl/arith_enc_ctrl.sv */
// Controller state machine of the arithmetic encoder.
// Depends on arith_enc_pkg; drives the datapath through dp_cmd_t.
module arith_enc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  arith_enc_pkg::dp_stat_t stat,
  output arith_enc_pkg::dp_cmd_t  cmd,
  input  logic                    out_valid,
  input  logic                    out_ready
);
  import arith_enc_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A step that may emit a byte waits while the output register is full.
  logic stall;
  assign stall = stat.out_full && !(out_valid && out_ready);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.take = out_valid && out_ready;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat.div_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_RENORM;
      end
      ST_RENORM: begin
        if (stat.renorm_stop) begin
          state_next = stat.is_finish ? ST_TAIL : ST_FLUSH;
        end else if (!stall) begin
          cmd.renorm = 1'b1;
          state_next = stat.renorm_mid ? ST_RENORM : ST_FOLLOW;
        end
      end
      ST_FOLLOW: begin
        if (stat.pending_zero) begin
          state_next = ST_RENORM;
        end else if (!stall) begin
          cmd.follow = 1'b1;
        end
      end
      ST_TAIL: begin
        if (!stall) begin
          cmd.tail = 1'b1;
          state_next = ST_FOLLOW;
        end
      end
      ST_FLUSH: begin
        if (!stall) begin
          cmd.flush = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // The datapath clears is_finish on tail, so the FOLLOW drain after the tail
  // comes back to RENORM, which sees renorm_stop and goes to FLUSH.

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == ST_IDLE)
    else $error("input taken outside idle");
  a_emit_space: assert property (@(posedge clk) disable iff (rst)
    (cmd.renorm || cmd.follow || cmd.tail || cmd.flush) |-> !stall)
    else $error("emit step while output full");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE)
    else $error("ready outside idle");
endmodule

/* rtl/arith_enc_div.sv */
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on nothing; used by the arithmetic encoder datapath.
module arith_enc_div #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], q[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        rem  <= '0;
        d    <= den;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = q;
endmodule

/* rtl/arith_enc_dp.sv */
// Datapath of the arithmetic encoder: interval, products, bit packer, output.
// Depends on arith_enc_pkg and arith_enc_div.
module arith_enc_dp #(
  parameter int CODE_BITS   = 16,
  parameter int PENDING_MAX = 127
) (
  input  logic                     clk,
  input  logic                     rst,
  input  arith_enc_pkg::in_word_t  in_word,
  input  arith_enc_pkg::dp_cmd_t   cmd,
  output arith_enc_pkg::dp_stat_t  stat,
  output arith_enc_pkg::out_word_t out_word,
  output logic                     out_valid
);
  import arith_enc_pkg::*;

  localparam int PROD_W = CODE_BITS + 1 + FREQ_W;
  localparam int PEND_W = $clog2(PENDING_MAX + 1);
  localparam logic [CODE_BITS-1:0] HALF = CODE_BITS'(1) << (CODE_BITS - 1);
  localparam logic [CODE_BITS-1:0] QTR1 = CODE_BITS'(1) << (CODE_BITS - 2);
  localparam logic [CODE_BITS-1:0] QTR3 = HALF + QTR1;

  logic [CODE_BITS-1:0] low, high;
  logic [PEND_W-1:0]    pending;
  logic [7:0]           shifter;
  logic [3:0]           bits_left;
  logic [COUNT_W-1:0]   byte_count;
  logic                 ovf, finish, follow_bit;
  in_word_t             iw;
  logic [FREQ_W-1:0]    den;
  logic [PROD_W-1:0]    prod_u, prod_l, div_num, qu;
  logic [CODE_BITS:0]   range;
  logic                 div_start, div_done, second;

  assign range = ({1'b0, high} - {1'b0, low} + 1'b1);
  assign den   = (iw.total_count == '0) ? FREQ_W'(1) : iw.total_count;

  arith_enc_div #(.NUM_W(PROD_W), .DEN_W(FREQ_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(den),
    .quo(qu), .done(div_done)
  );

  // Both quotients share the divider: upper bound first, then lower.
  logic [PROD_W-1:0] q_up;
  assign div_start = cmd.div_start || (div_done && !second);
  assign div_num   = cmd.div_start ? prod_u : prod_l;

  // Renormalization case decode.
  logic case_lo, case_hi, case_mid;
  assign case_lo  = high < HALF;
  assign case_hi  = !case_lo && low >= HALF;
  assign case_mid = !case_lo && !case_hi && low >= QTR1 && high < QTR3;

  // One bit into the packer, possibly completing a byte.
  logic       put_en, put_bit, put_full;
  logic [7:0] sh_new;
  assign sh_new   = {put_bit, shifter[7:1]};
  assign put_full = put_en && bits_left == 4'd1;

  logic [PEND_W-1:0] pend_bump;
  assign pend_bump = (pending < PEND_W'(PENDING_MAX)) ? pending + 1'b1 : pending;

  // The tail bumps the follow count before its bit, so the flag it sets
  // already applies to a byte that the tail bit completes.
  logic ovf_now;
  assign ovf_now = ovf || (cmd.tail && pend_bump >= PEND_W'(PENDING_MAX));

  always_comb begin
    put_en  = 1'b0;
    put_bit = 1'b0;
    if (cmd.renorm && !case_mid) begin
      put_en  = 1'b1;
      put_bit = case_hi;
    end else if (cmd.follow) begin
      put_en  = 1'b1;
      put_bit = !follow_bit;
    end else if (cmd.tail) begin
      put_en  = 1'b1;
      put_bit = low >= QTR1;
    end
  end

  // Bytes of an encode word wait in the hold register until the next byte
  // or the flush shows whether they are the last of the word.
  logic [7:0] hold_byte;
  logic       hold_ovf, hold_valid;
  logic       out_load;
  out_word_t  out_next;

  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (put_full && iw.func) begin
      out_load = 1'b1;
      out_next.out_byte = sh_new;
      out_next.pending_saturated = ovf_now;
    end else if (put_full && hold_valid) begin
      out_load = 1'b1;
      out_next.out_byte = hold_byte;
      out_next.pending_saturated = hold_ovf;
    end else if (cmd.flush && iw.func) begin
      out_load = 1'b1;
      out_next.out_byte = shifter >> bits_left;
      out_next.run_last = 1'b1;
      out_next.stream_bytes = byte_count + 1'b1;
      out_next.pending_saturated = ovf;
    end else if (cmd.flush && hold_valid) begin
      out_load = 1'b1;
      out_next.out_byte = hold_byte;
      out_next.run_last = 1'b1;
      out_next.pending_saturated = hold_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low <= '0; high <= '1; pending <= '0; shifter <= '0;
      bits_left <= 4'd8; byte_count <= '0; ovf <= 1'b0;
      out_valid <= 1'b0; second <= 1'b1; finish <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !cmd.take);
      if (out_load) out_word <= out_next;
      if (cmd.load) begin
        iw <= in_word;
        finish <= in_word.func;
      end
      if (cmd.mul) begin
        prod_u <= PROD_W'(range) * PROD_W'(iw.cum_upper);
        prod_l <= PROD_W'(range) * PROD_W'(iw.cum_lower);
      end
      if (cmd.div_start) second <= 1'b0;
      if (div_done && !second) begin
        q_up   <= qu;
        second <= 1'b1;
      end
      if (cmd.update) begin
        high <= low + CODE_BITS'(q_up) - 1'b1;
        low  <= low + CODE_BITS'(qu);
      end
      if (cmd.renorm) begin
        follow_bit <= case_hi;
        if (case_mid) begin
          pending <= pend_bump;
          if (pend_bump >= PEND_W'(PENDING_MAX)) ovf <= 1'b1;
          low  <= (low - QTR1) << 1;
          high <= ((high - QTR1) << 1) | CODE_BITS'(1);
        end else begin
          low  <= (case_hi ? low - HALF : low) << 1;
          high <= ((case_hi ? high - HALF : high) << 1) | CODE_BITS'(1);
        end
      end
      if (cmd.follow) pending <= pending - 1'b1;
      if (cmd.tail) begin
        follow_bit <= low >= QTR1;
        finish <= 1'b0;
        pending <= pend_bump;
        if (pend_bump >= PEND_W'(PENDING_MAX)) ovf <= 1'b1;
      end
      if (put_en) begin
        shifter <= sh_new;
        bits_left <= put_full ? 4'd8 : bits_left - 1'b1;
        if (put_full) byte_count <= byte_count + 1'b1;
      end
      if (put_full && !iw.func) begin
        hold_byte  <= sh_new;
        hold_ovf   <= ovf_now;
        hold_valid <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      if (cmd.flush && iw.func) begin
        low <= '0; high <= '1; pending <= '0; shifter <= '0;
        bits_left <= 4'd8; byte_count <= '0; ovf <= 1'b0;
      end
    end
  end

  assign stat.div_done     = div_done && second;
  assign stat.renorm_stop  = !case_lo && !case_hi && !case_mid;
  assign stat.renorm_mid   = case_mid;
  assign stat.pending_zero = pending == '0;
  assign stat.out_full     = out_valid;
  assign stat.is_finish    = finish;

  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    bits_left != 4'd0 && bits_left <= 4'd8)
    else $error("bit count out of range");
  a_pend_max: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(PENDING_MAX))
    else $error("pending count above limit");
  a_flush_reset: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush && iw.func) |=> (bits_left == 4'd8 && byte_count == '0))
    else $error("finish did not restore state");
endmodule

/* rtl/arithmetic_encoder.sv */
// Top level of the arithmetic encoder: controller plus datapath.
// Depends on arith_enc_pkg, arith_enc_ctrl, arith_enc_dp.
//
// Input channel (in_valid/in_ready/in_data) takes one word per symbol:
// cumulative bounds and model total. func=1 encodes the end symbol,
// emits the tail bits and the last partial byte, then returns the
// state to its reset values. Output channel (out_valid/out_ready/out_data)
// delivers each completed byte, first coded bit in bit 0. The last byte
// caused by a word carries run_last; on a finish word it also carries the
// stream byte count. Bytes of an encode word are held back by one byte so
// that the last one can be marked at flush. Words are handled one at a
// time: a load step, a multiply step, a divider start step, a shared
// bit-serial divider run twice back to back, an update step, then the
// renormalization steps, each one that decides a bit followed by its
// follow bits, a final check and a flush; a finish word adds the tail
// and its follow bits before the flush. A stalled receiver holds the
// output word and every step that may emit a byte waits on it; the input
// is ready only when the block is idle. Synchronous reset clears the
// control state, the interval, the follow count and the bit packer.
module arithmetic_encoder #(
  parameter int CODE_BITS   = 16,
  parameter int PENDING_MAX = 127
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  arith_enc_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output arith_enc_pkg::out_word_t out_data
);
  import arith_enc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  arith_enc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready)
  );

  arith_enc_dp #(.CODE_BITS(CODE_BITS), .PENDING_MAX(PENDING_MAX)) u_dp (
    .clk(clk), .rst(rst), .in_word(in_data), .cmd(cmd), .stat(stat),
    .out_word(out_data), .out_valid(out_valid)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output word dropped");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while busy");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_data.out_byte))
    else $error("output byte changed while stalled");
endmodule
